FILE: rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/mshr_pkg.sv
// types, codes and sizes shared by the miss status holding register file
`timescale 1ns / 1ps
`default_nettype none
package mshr_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAX_RES = 16;
	localparam int CNT_W = $clog2(MAX_RES);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEND_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_DELAY = 2'd2;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_ALLOC = 3'd1;
	localparam logic [2:0] MODE_LOOKUP = 3'd2;
	localparam logic [2:0] MODE_FREE = 3'd3;
	localparam logic [2:0] MODE_MEM_DONE = 3'd4;
	localparam logic [2:0] MODE_QUERY = 3'd5;

	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_REQ = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;

	typedef enum logic [1:0] {
		PH_SEND = 2'd0,
		PH_MEM = 2'd1,
		PH_FILL = 2'd2,
		PH_READY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [31:0] address;
		logic miss_write;
		logic is_fetch;
		logic [3:0] entry_index;
	} mshr_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic success;
		logic [3:0] entry_out;
		logic ready_res;
		logic any_free;
		logic [31:0] req_address;
		logic req_write;
		logic req_fetch;
		logic last;
	} mshr_out_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_EXEC = 2'd1,
		OP_TICK_EVAL = 2'd2,
		OP_TICK_STEP = 2'd3
	} dp_op_t;

	typedef struct packed {
		logic capture;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic pend_any;
		logic step_last;
	} dp_status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_WALK = 2'd2
	} ctrl_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/mshr_ctrl.sv
// controller state machine sequencing operations and tick walks
`timescale 1ns / 1ps
`default_nettype none
module mshr_ctrl
	import mshr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic out_free,
	input wire dp_status_t status,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.capture = 1'b0;
		cmd.op = OP_NONE;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_tick) begin
					cmd.op = OP_TICK_EVAL;
					state_nxt = ST_WALK;
				end else if (out_free) begin
					cmd.op = OP_EXEC;
					state_nxt = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (!status.pend_any) begin
					state_nxt = ST_IDLE;
				end else if (out_free) begin
					cmd.op = OP_TICK_STEP;
					if (status.step_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/mshr_dp.sv
// datapath: entry table, configuration registers and result formation
`timescale 1ns / 1ps
`default_nettype none
module mshr_dp
	import mshr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire mshr_in_t in_data,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input wire dp_cmd_t cmd,
	output dp_status_t status,
	output mshr_out_t res
);

	function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [3:0] entry_code(input logic [IDX_W-1:0] i);
		logic [IDX_W+3:0] w;
		w = {4'b0000, i};
		return w[3:0];
	endfunction

	// configuration
	logic [2:0] line_log2_q;
	logic [7:0] send_delay_q;
	logic [7:0] fill_delay_q;

	// held item and entry table
	mshr_in_t item_q;
	logic [ENTRIES-1:0] valid_q;
	phase_t phase_q [ENTRIES];
	logic [31:0] line_q [ENTRIES];
	logic [31:0] due_q [ENTRIES];
	logic [ENTRIES-1:0] write_q;
	logic [ENTRIES-1:0] fetch_q;
	logic [31:0] cycle_q;

	// tick walk
	logic [ENTRIES-1:0] pend_q;
	logic [ENTRIES-1:0] req_kind_q;
	logic [CNT_W-1:0] sent_cnt_q;

	logic [31:0] aligned;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] done_vec;
	logic [ENTRIES-1:0] chg_vec;
	logic [IDX_W-1:0] alloc_idx;
	logic [IDX_W-1:0] match_idx;
	logic [IDX_W-1:0] step_idx;
	logic [IDX_W-1:0] q_idx;
	logic [IDX_W+3:0] q_ext;
	logic alloc_hit;
	logic q_in_range;
	logic step_last;
	logic any_free_now;
	logic [31:0] send_due;
	logic [31:0] fill_due;

	assign aligned = item_q.address & (32'hFFFF_FFFF << line_log2_q);
	assign free_vec = ~valid_q;
	assign alloc_hit = |free_vec;
	assign any_free_now = |free_vec;
	assign alloc_idx = first_set(free_vec);
	assign match_idx = first_set(match_vec);
	assign step_idx = first_set(pend_q);
	assign q_ext = {{IDX_W{1'b0}}, item_q.entry_index};
	assign q_idx = q_ext[IDX_W-1:0];
	assign q_in_range = int'(item_q.entry_index) < ENTRIES;
	assign send_due = cycle_q + {24'd0, send_delay_q};
	assign fill_due = cycle_q + {24'd0, fill_delay_q};

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (line_q[i] == aligned);
			done_vec[i] = valid_q[i] && (line_q[i] == item_q.address) && (phase_q[i] == PH_MEM);
			chg_vec[i] = valid_q[i] && (cycle_q >= due_q[i])
				&& ((phase_q[i] == PH_SEND) || (phase_q[i] == PH_FILL));
		end
	end

	// last report: nothing left behind, or the report slots are used up
	assign step_last = ((pend_q & ~(ENTRIES'(1) << step_idx)) == '0)
		|| (sent_cnt_q == CNT_W'(MAX_RES - 1));

	assign status.is_tick = (item_q.mode == MODE_TICK);
	assign status.pend_any = |pend_q;
	assign status.step_last = step_last;

	always_comb begin
		res = '0;
		res.last = 1'b1;
		res.any_free = any_free_now;
		if (cmd.op == OP_TICK_STEP) begin
			res.entry_out = entry_code(step_idx);
			res.last = step_last;
			if (req_kind_q[step_idx]) begin
				res.kind = KIND_REQ;
				res.req_address = line_q[step_idx];
				res.req_write = write_q[step_idx];
				res.req_fetch = fetch_q[step_idx];
			end else begin
				res.kind = KIND_FILL;
			end
		end else begin
			res.kind = KIND_REPLY;
			case (item_q.mode)
				MODE_ALLOC: begin
					res.success = alloc_hit;
					res.entry_out = alloc_hit ? entry_code(alloc_idx) : 4'd0;
					res.any_free = alloc_hit && |(free_vec & ~(ENTRIES'(1) << alloc_idx));
				end
				MODE_LOOKUP: begin
					res.success = |match_vec;
					res.entry_out = (|match_vec) ? entry_code(match_idx) : 4'd0;
				end
				MODE_FREE: begin
					res.entry_out = item_q.entry_index;
					res.any_free = q_in_range || any_free_now;
				end
				MODE_QUERY: begin
					res.entry_out = item_q.entry_index;
					res.ready_res = q_in_range && valid_q[q_idx] && (phase_q[q_idx] == PH_READY);
				end
				default: begin
				end
			endcase
		end
	end

	// control state: configuration, validity, phases, counter, walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_log2_q <= 3'd6;
			send_delay_q <= 8'd5;
			fill_delay_q <= 8'd5;
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				phase_q[i] <= PH_SEND;
			end
			cycle_q <= '0;
			pend_q <= '0;
			sent_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_LINE_SIZE: line_log2_q <= cfg_wdata[2:0];
					CFG_SEND_DELAY: send_delay_q <= cfg_wdata;
					CFG_FILL_DELAY: fill_delay_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (cmd.op)
				OP_EXEC: begin
					case (item_q.mode)
						MODE_ALLOC: begin
							if (alloc_hit) begin
								valid_q[alloc_idx] <= 1'b1;
								phase_q[alloc_idx] <= PH_SEND;
							end
						end
						MODE_FREE: begin
							if (q_in_range) begin
								valid_q[q_idx] <= 1'b0;
								phase_q[q_idx] <= PH_SEND;
							end
						end
						MODE_MEM_DONE: begin
							for (int i = 0; i < ENTRIES; i++) begin
								if (done_vec[i]) begin
									phase_q[i] <= PH_FILL;
								end
							end
						end
						default: begin
						end
					endcase
				end
				OP_TICK_EVAL: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (chg_vec[i]) begin
							phase_q[i] <= (phase_q[i] == PH_SEND) ? PH_MEM : PH_READY;
						end
					end
					pend_q <= chg_vec;
					sent_cnt_q <= '0;
					cycle_q <= cycle_q + 32'd1;
				end
				OP_TICK_STEP: begin
					if (step_last) begin
						pend_q <= '0;
					end else begin
						pend_q[step_idx] <= 1'b0;
					end
					sent_cnt_q <= sent_cnt_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// payload state, only read where the entry is valid
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
		if ((cmd.op == OP_EXEC) && (item_q.mode == MODE_ALLOC) && alloc_hit) begin
			line_q[alloc_idx] <= aligned;
			due_q[alloc_idx] <= send_due;
			write_q[alloc_idx] <= item_q.miss_write;
			fetch_q[alloc_idx] <= item_q.is_fetch;
		end
		if ((cmd.op == OP_EXEC) && (item_q.mode == MODE_MEM_DONE)) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (done_vec[i]) begin
					due_q[i] <= fill_due;
				end
			end
		end
		if (cmd.op == OP_TICK_EVAL) begin
			for (int i = 0; i < ENTRIES; i++) begin
				req_kind_q[i] <= (phase_q[i] == PH_SEND);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/miss_status_holding_registers.sv
// top level of the miss status holding register file
//
//   channel  signals                          direction  transfer when
//   in       in_valid, in_stall, in_data      into block in_valid && !in_stall
//   out      out_valid, out_stall, out_data   out of     out_valid && !out_stall
//   cfg      cfg_we, cfg_idx, cfg_wdata       into block cfg_we
//
// a non-tick operation is taken into the held item register, then executed into the
// output register, waiting only while that register is still held
// a tick is taken, evaluated, then walked: the walk emits one change per cycle while
// the output register is free, from the lowest pending entry up
// reset clears every valid bit at once, so no clearing pass is needed
// a stalled output holds the result; a new item is taken meanwhile and waits
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module miss_status_holding_registers
	import mshr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire mshr_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output mshr_out_t out_data,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_idx,
	input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_status_t status;
	mshr_out_t res;
	logic out_valid_q;
	mshr_out_t out_q;
	logic out_free;
	logic out_load;

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	// both a reply and a walk step produce a result
	assign out_load = (cmd.op == OP_EXEC) || (cmd.op == OP_TICK_STEP);

	mshr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_free(out_free),
		.status(status),
		.cmd(cmd)
	);

	mshr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.status(status),
		.res(res)
	);

	// output stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// a result never overwrites one that is still waiting
	`ASSERT_IMPLY(a_load_when_free, clk, arst_n, out_load, out_free, "result overwritten")
	// one item at a time: after a transfer in, the input side stalls
	`ASSERT_NEXT(a_stall_after_take, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken")
	// the last report of a tick leaves nothing pending
	`ASSERT_NEXT(a_walk_ends, clk, arst_n, (cmd.op == OP_TICK_STEP) && status.step_last, !status.pend_any, "walk left pending entries")
	// a loaded result shows on the output next cycle
	`ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, out_valid, "loaded result not presented")

endmodule
`default_nettype wire

FILE: tb/sv/miss_status_holding_registers_tb.sv
// self-checking testbench for the miss status holding register file
`timescale 1ns / 1ps
module miss_status_holding_registers_tb;
	import mshr_pkg::*;

	// modes outside the defined set, answered with an empty reply
	localparam logic [2:0] MODE_BAD_LO = 3'd6;
	localparam logic [2:0] MODE_BAD_HI = 3'd7;

	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PER_SET = 26;
	localparam int BURST_ALLOCS = ENTRIES + 1;

	typedef struct {
		mshr_in_t item;
		bit typed;
		mshr_out_t reply;
	} dir_row_t;

	typedef struct {
		logic [2:0] line_log2;
		logic [7:0] send_wait;
		logic [7:0] fill_wait;
	} reg_set_t;

	// register settings walked after the directed part, extremes included
	reg_set_t reg_sets [6] = '{
		'{3'd2, 8'd0, 8'd0},
		'{3'd7, 8'd255, 8'd255},
		'{3'd4, 8'd3, 8'd1},
		'{3'd7, 8'd1, 8'd255},
		'{3'd2, 8'd255, 8'd0},
		'{3'd5, 8'd2, 8'd2}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mshr_in_t in_data;
	logic out_valid;
	logic out_stall;
	mshr_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of the entry table, counter and registers
	logic tbl_valid [ENTRIES];
	phase_t tbl_phase [ENTRIES];
	logic [31:0] tbl_line [ENTRIES];
	logic tbl_write [ENTRIES];
	logic tbl_fetch [ENTRIES];
	logic [31:0] tbl_due [ENTRIES];
	logic [31:0] tick_count;
	logic [2:0] line_log2;
	logic [7:0] send_wait;
	logic [7:0] fill_wait;

	mshr_out_t step_results [$];
	mshr_out_t awaited_results [$];
	dir_row_t dir_rows [$];
	int error_count = 0;
	bit calm = 1'b0;
	logic [31:0] pool_base;

	miss_status_holding_registers DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_result(input mshr_out_t got, input mshr_out_t want);
		if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.success !== want.success)
			report_mismatch("success", 32'(got.success), 32'(want.success));
		if (got.entry_out !== want.entry_out)
			report_mismatch("entry_out", 32'(got.entry_out), 32'(want.entry_out));
		if (got.ready_res !== want.ready_res)
			report_mismatch("ready_res", 32'(got.ready_res), 32'(want.ready_res));
		if (got.any_free !== want.any_free)
			report_mismatch("any_free", 32'(got.any_free), 32'(want.any_free));
		if (got.req_address !== want.req_address)
			report_mismatch("req_address", got.req_address, want.req_address);
		if (got.req_write !== want.req_write)
			report_mismatch("req_write", 32'(got.req_write), 32'(want.req_write));
		if (got.req_fetch !== want.req_fetch)
			report_mismatch("req_fetch", 32'(got.req_fetch), 32'(want.req_fetch));
		if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// works out the results of one accepted item into step_results and
	// advances the predictor state
	task automatic predict_results(input mshr_in_t it);
		mshr_out_t r;
		logic [31:0] mask;
		bit found;
		bit free_left;
		int i;
		step_results.delete();
		mask = ~((32'd1 << line_log2) - 32'd1);
		r = '0;
		r.kind = KIND_REPLY;
		case (it.mode)
			MODE_TICK: begin
				// walk upward, at most one phase change per entry
				for (i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i] && tick_count >= tbl_due[i]) begin
						r = '0;
						r.entry_out = 4'(i);
						if (tbl_phase[i] == PH_SEND) begin
							tbl_phase[i] = PH_MEM;
							r.kind = KIND_REQ;
							r.req_address = tbl_line[i];
							r.req_write = tbl_write[i];
							r.req_fetch = tbl_fetch[i];
							if (step_results.size() < MAX_RES) step_results.push_back(r);
						end else if (tbl_phase[i] == PH_FILL) begin
							tbl_phase[i] = PH_READY;
							r.kind = KIND_FILL;
							if (step_results.size() < MAX_RES) step_results.push_back(r);
						end
					end
				end
				tick_count = tick_count + 32'd1;
			end
			MODE_ALLOC: begin
				found = 1'b0;
				for (i = 0; i < ENTRIES; i++) begin
					if (!found && !tbl_valid[i]) begin
						found = 1'b1;
						tbl_valid[i] = 1'b1;
						tbl_line[i] = it.address & mask;
						tbl_phase[i] = PH_SEND;
						tbl_due[i] = tick_count + 32'(send_wait);
						tbl_write[i] = it.miss_write;
						tbl_fetch[i] = it.is_fetch;
						r.success = 1'b1;
						r.entry_out = 4'(i);
					end
				end
				step_results.push_back(r);
			end
			MODE_LOOKUP: begin
				found = 1'b0;
				for (i = 0; i < ENTRIES; i++) begin
					if (!found && tbl_valid[i] && tbl_line[i] == (it.address & mask)) begin
						found = 1'b1;
						r.success = 1'b1;
						r.entry_out = 4'(i);
					end
				end
				step_results.push_back(r);
			end
			MODE_FREE: begin
				tbl_valid[it.entry_index] = 1'b0;
				tbl_phase[it.entry_index] = PH_SEND;
				r.entry_out = it.entry_index;
				step_results.push_back(r);
			end
			MODE_MEM_DONE: begin
				// exact address compare, no line alignment here
				for (i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i] && tbl_line[i] == it.address && tbl_phase[i] == PH_MEM) begin
						tbl_phase[i] = PH_FILL;
						tbl_due[i] = tick_count + 32'(fill_wait);
					end
				end
				step_results.push_back(r);
			end
			MODE_QUERY: begin
				r.entry_out = it.entry_index;
				r.ready_res = tbl_valid[it.entry_index] && tbl_phase[it.entry_index] == PH_READY;
				step_results.push_back(r);
			end
			default: begin
				step_results.push_back(r);
			end
		endcase
		free_left = 1'b0;
		for (i = 0; i < ENTRIES; i++) if (!tbl_valid[i]) free_left = 1'b1;
		for (i = 0; i < step_results.size(); i++) begin
			step_results[i].any_free = free_left;
			step_results[i].last = (i == step_results.size() - 1);
		end
	endtask

	// random valid entry, optionally only one waiting on memory; -1 if none
	function automatic int pick_entry(input bit want_mem);
		int cand [$];
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && (!want_mem || tbl_phase[i] == PH_MEM)) cand.push_back(i);
		if (cand.size() == 0) return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	function automatic logic [31:0] pool_address();
		if ($urandom_range(0, 9) < 7)
			return pool_base + ($urandom_range(0, 7) << 7) + $urandom_range(0, 127);
		return $urandom;
	endfunction

	// mostly well-formed miss traffic steered by the predictor state, some noise
	function automatic mshr_in_t random_item();
		mshr_in_t it;
		int roll;
		int e;
		it.address = $urandom;
		it.miss_write = 1'($urandom_range(0, 1));
		it.is_fetch = 1'($urandom_range(0, 1));
		it.entry_index = 4'($urandom_range(0, 15));
		roll = $urandom_range(0, 99);
		if (roll < 34) begin
			it.mode = MODE_TICK;
		end else if (roll < 54) begin
			it.mode = MODE_ALLOC;
			it.address = pool_address();
		end else if (roll < 64) begin
			it.mode = MODE_LOOKUP;
			e = pick_entry(1'b0);
			if (e >= 0 && $urandom_range(0, 9) < 6)
				it.address = tbl_line[e] | ($urandom & ((32'd1 << line_log2) - 32'd1));
			else
				it.address = pool_address();
		end else if (roll < 76) begin
			it.mode = MODE_FREE;
			e = pick_entry(1'b0);
			if (e >= 0 && $urandom_range(0, 9) < 7) it.entry_index = 4'(e);
		end else if (roll < 88) begin
			it.mode = MODE_MEM_DONE;
			e = pick_entry(1'b1);
			if (e < 0) e = pick_entry(1'b0);
			if (e >= 0 && $urandom_range(0, 9) < 8) it.address = tbl_line[e];
		end else if (roll < 96) begin
			it.mode = MODE_QUERY;
			e = pick_entry(1'b0);
			if (e >= 0 && $urandom_range(0, 9) < 7) it.entry_index = 4'(e);
		end else begin
			it.mode = $urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO;
		end
		return it;
	endfunction

	// one input transfer after a random gap; the results are predicted at acceptance
	task automatic send_item(input mshr_in_t it, input bit typed, input mshr_out_t typed_reply);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_results(it);
		if (typed) begin
			awaited_results.push_back(typed_reply);
		end else begin
			foreach (step_results[k]) awaited_results.push_back(step_results[k]);
		end
	endtask

	// lower valid, wait for every awaited result, then let the design settle
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LINE_SIZE: line_log2 = value[2:0];
			CFG_SEND_DELAY: send_wait = value;
			CFG_FILL_DELAY: fill_wait = value;
			default: ;
		endcase
	endtask

	// directed row; a typed reply is a single operation reply with entries still free
	task automatic add_row(input logic [2:0] mode, input logic [31:0] address,
			input logic wr, input logic fe, input logic [3:0] idx, input bit typed,
			input logic success, input logic [3:0] entry, input logic ready);
		dir_row_t row;
		row.item = '{mode: mode, address: address, miss_write: wr, is_fetch: fe,
			entry_index: idx};
		row.typed = typed;
		row.reply = '0;
		row.reply.kind = KIND_REPLY;
		row.reply.success = success;
		row.reply.entry_out = entry;
		row.reply.ready_res = ready;
		row.reply.any_free = 1'b1;
		row.reply.last = 1'b1;
		dir_rows.push_back(row);
	endtask

	// result checking against the oldest awaited result
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_results.size() == 0)
				report_mismatch("result with none awaited, entry_out",
					32'(out_data.entry_out), '0);
			else
				check_result(out_data, awaited_results.pop_front());
		end
	end

	// output stall: a random hold before each result transfer
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			@(negedge clk);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// stimulus
	initial begin
		int s;
		int i;
		mshr_in_t it;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		for (i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_phase[i] = PH_SEND;
			tbl_line[i] = '0;
			tbl_write[i] = 1'b0;
			tbl_fetch[i] = 1'b0;
			tbl_due[i] = '0;
		end
		tick_count = '0;
		line_log2 = 3'd6;
		send_wait = 8'd5;
		fill_wait = 8'd5;
		pool_base = $urandom;

		// reset values: 64-byte lines, both delays 5
		add_row(MODE_QUERY, 32'h0, 1'b0, 1'b0, 4'd15, 1'b1, 1'b0, 4'd15, 1'b0);
		add_row(MODE_BAD_HI, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15, 1'b1, 1'b0, 4'd0, 1'b0);
		add_row(MODE_BAD_LO, 32'h0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);
		add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);
		add_row(MODE_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd9, 1'b1, 1'b1, 4'd0, 1'b0);
		add_row(MODE_ALLOC, 32'h0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 4'd1, 1'b0);
		// any byte of the line hits
		add_row(MODE_LOOKUP, 32'hFFFF_FFC5, 1'b0, 1'b0, 4'd0, 1'b1, 1'b1, 4'd0, 1'b0);
		// freeing an entry never allocated still echoes the index
		add_row(MODE_FREE, 32'h0, 1'b0, 1'b0, 4'd15, 1'b1, 1'b0, 4'd15, 1'b0);
		// first tick changes nothing, the sixth issues both requests in entry order
		repeat (6) add_row(MODE_TICK, 32'h0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0);
		add_row(MODE_MEM_DONE, 32'hFFFF_FFC0, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);
		// completion needs the exact line address, so this one matches nothing
		add_row(MODE_MEM_DONE, 32'h1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);
		add_row(MODE_QUERY, 32'h0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);
		repeat (6) add_row(MODE_TICK, 32'h0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0);
		add_row(MODE_QUERY, 32'h0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0);
		add_row(MODE_FREE, 32'h0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].reply);
		drain_block();

		for (s = 0; s < 6; s++) begin
			write_reg(CFG_LINE_SIZE, {5'd0, reg_sets[s].line_log2});
			write_reg(CFG_SEND_DELAY, reg_sets[s].send_wait);
			write_reg(CFG_FILL_DELAY, reg_sets[s].fill_wait);
			calm = (s == 2);
			pool_base = $urandom;
			// allocation burst past a full table, so the next due tick reports many changes
			if (s % 2 == 0) begin
				for (i = 0; i < BURST_ALLOCS; i++) begin
					it = random_item();
					it.mode = MODE_ALLOC;
					it.address = pool_address();
					send_item(it, 1'b0, '0);
				end
			end
			repeat (RANDOM_PER_SET) send_item(random_item(), 1'b0, '0);
			drain_block();
		end

		if (error_count == 0 && awaited_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/mshr_pkg.sv
rtl/core/mshr_ctrl.sv
rtl/core/mshr_dp.sv
rtl/core/miss_status_holding_registers.sv
tb/sv/miss_status_holding_registers_tb.sv
